FILE: hdl/wss_pkg.sv
// Package for the work-stealing task scheduler: sizes, item structs,
// deque and worker state types, event codes and helper functions.
// No dependencies; used by wss_worker and the top level.
package wss_pkg;

    localparam int DEQUE_DEPTH = 4;
    localparam int ID_BITS     = 16;
    localparam int TIME_BITS   = 4;
    localparam int NUM_WORKERS = 3;

    localparam int CNT_BITS = $clog2(DEQUE_DEPTH + 1);
    localparam int IDX_BITS = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;

    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEQUE_DEPTH);
    localparam logic [19:0]         TIME_MAX  = 20'((64'd1 << TIME_BITS) - 64'd1);

    typedef enum logic [2:0] {
        EV_IDLE   = 3'd0,
        EV_WORK   = 3'd1,
        EV_OWN    = 3'd2,
        EV_STEAL1 = 3'd3,
        EV_STEAL2 = 3'd4
    } t_event;

    typedef struct packed {
        logic       new_task_valid;
        logic [3:0] task_duration;
    } t_in_item;

    typedef struct packed {
        logic [15:0] assigned_id;
        logic        overflow;
        logic [2:0]  worker0_event;
        logic [15:0] worker0_task;
        logic [2:0]  worker1_event;
        logic [15:0] worker1_task;
        logic [2:0]  worker2_event;
        logic [15:0] worker2_task;
        logic [2:0]  depth0;
        logic [2:0]  depth1;
        logic [2:0]  depth2;
    } t_out_item;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] dur;
    } t_entry;

    // Front of the deque always sits in slot 0; rear is slot cnt-1.
    typedef struct packed {
        t_entry [DEQUE_DEPTH-1:0] slot;
        logic [CNT_BITS-1:0]      cnt;
    } t_deque;

    typedef struct packed {
        logic [TIME_BITS-1:0] rem;
        logic [ID_BITS-1:0]   run_id;
        logic                 run_vld;
    } t_wstate;

    function automatic t_entry deque_rear(input t_deque d);
        logic [CNT_BITS-1:0] k;
        k = d.cnt - CNT_BITS'(1);
        return d.slot[k[IDX_BITS-1:0]];
    endfunction

    function automatic logic [15:0] id_out(input logic [ID_BITS-1:0] id);
        logic [ID_BITS+15:0] ext;
        ext = {16'b0, id};
        return ext[15:0];
    endfunction

    function automatic logic [2:0] cnt_out(input logic [CNT_BITS-1:0] c);
        logic [CNT_BITS+2:0] ext;
        ext = {3'b0, c};
        return ext[2:0];
    endfunction

    // Clamp the 4-bit duration to the largest value TIME_BITS can hold.
    function automatic logic [TIME_BITS-1:0] sat_dur(input logic [3:0] d);
        logic [19:0] ext;
        ext = {16'b0, d};
        if (ext > TIME_MAX) begin
            return '1;
        end
        return ext[TIME_BITS-1:0];
    endfunction

endpackage

FILE: hdl/wss_worker.sv
// One worker's action for a tick: count down, pop own front, steal a
// victim's rear, or stay idle. Purely combinational; uses wss_pkg.
module wss_worker (
    input  wss_pkg::t_deque  i_own,
    input  wss_pkg::t_deque  i_va,
    input  wss_pkg::t_deque  i_vb,
    input  wss_pkg::t_wstate i_ws_own,
    input  wss_pkg::t_wstate i_ws_va,
    input  wss_pkg::t_wstate i_ws_vb,
    output wss_pkg::t_deque  o_own,
    output wss_pkg::t_deque  o_va,
    output wss_pkg::t_deque  o_vb,
    output wss_pkg::t_wstate o_ws,
    output wss_pkg::t_event  o_event
);

    wss_pkg::t_entry rear_a;
    wss_pkg::t_entry rear_b;
    logic            may_a;
    logic            may_b;

    // A victim blocks the steal if it is empty or its rear is the task it runs.
    assign rear_a = wss_pkg::deque_rear(i_va);
    assign rear_b = wss_pkg::deque_rear(i_vb);
    assign may_a  = (i_va.cnt != '0) && !(i_ws_va.run_vld && rear_a.id == i_ws_va.run_id);
    assign may_b  = (i_vb.cnt != '0) && !(i_ws_vb.run_vld && rear_b.id == i_ws_vb.run_id);

    always_comb begin
        o_own   = i_own;
        o_va    = i_va;
        o_vb    = i_vb;
        o_ws    = i_ws_own;
        o_event = wss_pkg::EV_IDLE;
        if (i_ws_own.rem != '0) begin
            o_ws.rem = i_ws_own.rem - wss_pkg::TIME_BITS'(1);
            o_event  = wss_pkg::EV_WORK;
        end else if (i_own.cnt != '0) begin
            o_ws.run_id  = i_own.slot[0].id;
            o_ws.rem     = i_own.slot[0].dur;
            o_ws.run_vld = 1'b1;
            for (int i = 0; i < wss_pkg::DEQUE_DEPTH - 1; i++) begin
                o_own.slot[i] = i_own.slot[i+1];
            end
            o_own.cnt = i_own.cnt - wss_pkg::CNT_BITS'(1);
            o_event   = wss_pkg::EV_OWN;
        end else if (may_a) begin
            o_ws.run_id  = rear_a.id;
            o_ws.rem     = rear_a.dur;
            o_ws.run_vld = 1'b1;
            o_va.cnt     = i_va.cnt - wss_pkg::CNT_BITS'(1);
            o_event      = wss_pkg::EV_STEAL1;
        end else if (may_b) begin
            o_ws.run_id  = rear_b.id;
            o_ws.rem     = rear_b.dur;
            o_ws.run_vld = 1'b1;
            o_vb.cnt     = i_vb.cnt - wss_pkg::CNT_BITS'(1);
            o_event      = wss_pkg::EV_STEAL2;
        end
    end

endmodule

FILE: hdl/work_stealing_task_scheduler_top.sv
// Work-stealing scheduler top level: input register, one tick of logic
// (push to deque 0, then workers 0, 1, 2 in a chain), result register.
// Throughput: one item per cycle while the result register is taken, set by the
// combinational chain push -> worker0 -> worker1 -> worker2.
// Reset (i_rst_n low, synchronous): all deques empty, workers idle with no
// running task, id counter at zero, both pipeline registers empty.
module work_stealing_task_scheduler_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wss_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wss_pkg::t_out_item  o_out_item
);

    // Pipeline registers
    logic                r_in_vld;
    wss_pkg::t_in_item   r_in;
    logic                r_out_vld;
    wss_pkg::t_out_item  r_out;
    logic                fire;

    // Scheduler state: entry slots carry no reset, counts and workers do
    wss_pkg::t_entry [wss_pkg::DEQUE_DEPTH-1:0] r_slot [wss_pkg::NUM_WORKERS];
    logic [wss_pkg::CNT_BITS-1:0]               r_cnt  [wss_pkg::NUM_WORKERS];
    wss_pkg::t_wstate                           r_ws   [wss_pkg::NUM_WORKERS];
    logic [wss_pkg::ID_BITS-1:0]                r_next_id;

    logic [wss_pkg::ID_BITS-1:0] n_next_id;
    wss_pkg::t_out_item          n_out;
    logic                        ovf;

    wss_pkg::t_deque  dq1_in, dq2_in, dq0_push;
    wss_pkg::t_deque  a_own, a_va, a_vb;
    wss_pkg::t_deque  b_own, b_va, b_vb;
    wss_pkg::t_deque  c_own, c_va, c_vb;
    wss_pkg::t_wstate ws0_n, ws1_n, ws2_n;
    wss_pkg::t_event  ev0, ev1, ev2;

    // Process the held item when the result register is free or draining;
    // take a new item whenever the input register is empty or empties this cycle.
    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Push stage: append the new task to the rear of deque 0, or drop it
    assign dq1_in = '{slot: r_slot[1], cnt: r_cnt[1]};
    assign dq2_in = '{slot: r_slot[2], cnt: r_cnt[2]};

    always_comb begin
        dq0_push  = '{slot: r_slot[0], cnt: r_cnt[0]};
        n_next_id = r_next_id;
        ovf       = 1'b0;
        if (r_in.new_task_valid) begin
            if (r_cnt[0] >= wss_pkg::DEPTH_CNT) begin
                ovf = 1'b1;
            end else begin
                dq0_push.slot[r_cnt[0][wss_pkg::IDX_BITS-1:0]] =
                    '{id: r_next_id, dur: wss_pkg::sat_dur(r_in.task_duration)};
                dq0_push.cnt = r_cnt[0] + wss_pkg::CNT_BITS'(1);
                n_next_id    = r_next_id + wss_pkg::ID_BITS'(1);
            end
        end
    end

    // Worker 0: victims 1 then 2
    wss_worker u_worker0 (
        .i_own    (dq0_push),
        .i_va     (dq1_in),
        .i_vb     (dq2_in),
        .i_ws_own (r_ws[0]),
        .i_ws_va  (r_ws[1]),
        .i_ws_vb  (r_ws[2]),
        .o_own    (a_own),
        .o_va     (a_va),
        .o_vb     (a_vb),
        .o_ws     (ws0_n),
        .o_event  (ev0)
    );

    // Worker 1: victims 0 then 2, sees worker 0's updates
    wss_worker u_worker1 (
        .i_own    (a_va),
        .i_va     (a_own),
        .i_vb     (a_vb),
        .i_ws_own (r_ws[1]),
        .i_ws_va  (ws0_n),
        .i_ws_vb  (r_ws[2]),
        .o_own    (b_own),
        .o_va     (b_va),
        .o_vb     (b_vb),
        .o_ws     (ws1_n),
        .o_event  (ev1)
    );

    // Worker 2: victims 0 then 1
    wss_worker u_worker2 (
        .i_own    (b_vb),
        .i_va     (b_va),
        .i_vb     (b_own),
        .i_ws_own (r_ws[2]),
        .i_ws_va  (ws0_n),
        .i_ws_vb  (ws1_n),
        .o_own    (c_own),
        .o_va     (c_va),
        .o_vb     (c_vb),
        .o_ws     (ws2_n),
        .o_event  (ev2)
    );

    // Assemble the result item; a task id shows only when the worker is active
    always_comb begin
        n_out.assigned_id   = wss_pkg::id_out(r_next_id);
        n_out.overflow      = ovf;
        n_out.worker0_event = ev0;
        n_out.worker0_task  = (ev0 != wss_pkg::EV_IDLE) ? wss_pkg::id_out(ws0_n.run_id) : '0;
        n_out.worker1_event = ev1;
        n_out.worker1_task  = (ev1 != wss_pkg::EV_IDLE) ? wss_pkg::id_out(ws1_n.run_id) : '0;
        n_out.worker2_event = ev2;
        n_out.worker2_task  = (ev2 != wss_pkg::EV_IDLE) ? wss_pkg::id_out(ws2_n.run_id) : '0;
        n_out.depth0        = wss_pkg::cnt_out(c_va.cnt);
        n_out.depth1        = wss_pkg::cnt_out(c_vb.cnt);
        n_out.depth2        = wss_pkg::cnt_out(c_own.cnt);
    end

    // Commit control state on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= '0;
            for (int w = 0; w < wss_pkg::NUM_WORKERS; w++) begin
                r_cnt[w] <= '0;
                r_ws[w]  <= '0;
            end
        end else if (fire) begin
            r_next_id <= n_next_id;
            r_cnt[0]  <= c_va.cnt;
            r_cnt[1]  <= c_vb.cnt;
            r_cnt[2]  <= c_own.cnt;
            r_ws[0]   <= ws0_n;
            r_ws[1]   <= ws1_n;
            r_ws[2]   <= ws2_n;
        end
    end

    // Entry slots hold payload only
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_slot[0] <= c_va.slot;
            r_slot[1] <= c_vb.slot;
            r_slot[2] <= c_own.slot;
        end
    end

    // Result register: hold until taken, refill on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // Deques never hold more than their depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= wss_pkg::DEPTH_CNT && r_cnt[1] <= wss_pkg::DEPTH_CNT &&
        r_cnt[2] <= wss_pkg::DEPTH_CNT)
        else $error("deque count above depth");

    // Overflow only when deque 0 was full at push time
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_out.overflow |-> r_cnt[0] == wss_pkg::DEPTH_CNT)
        else $error("overflow raised with room in deque 0");

    // Id counter moves only on a processed item
    a_id_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_next_id))
        else $error("id counter changed without an item");

    // Worker 0 reports busy only while it had time left
    a_work_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_out.worker0_event == wss_pkg::EV_WORK |-> r_ws[0].rem != '0)
        else $error("worker 0 busy with no time left");

    // A processed item always lands in the result register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("result lost");

endmodule
